>>> rtl/ssm_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// ssm_pkg
// Shared constants and controller/datapath handshake types for the
// sorted stream merge.
// ============================================================================
package ssm_pkg;

    localparam int FIFO_DEPTH = 32;
    localparam int VALUE_W    = 32;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);

    // controller -> datapath
    typedef struct packed {
        logic take_item;    // store the element / end mark of the input item
        logic load_ovf;     // load the overflow report into the output register
        logic load_pop;     // pop the selected head into the output register
        logic load_marker;  // load the end-of-merge marker
        logic clear_merge;  // merge finished: clear end flags and pointers
    } ssm_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic ovf;          // input item would overflow its FIFO
        logic sel_valid;    // a head may be emitted now
        logic merge_over;   // both streams ended and both FIFOs empty
        logic out_done;     // output register holds the final item of a merge
    } ssm_status_t;

endpackage

>>> rtl/ssm_if.sv
`timescale 1ns / 1ps
// ============================================================================
// ssm_in_if / ssm_out_if
// Valid/ready channels carrying input items and merged result items.
// ============================================================================
interface ssm_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 mode;
    logic                                 has_value;
    logic signed [ssm_pkg::VALUE_W-1:0]   value;
    logic                                 end_of_stream;

    modport source (output valid, output mode, output has_value, output value,
                    output end_of_stream, input ready);
    modport sink   (input valid, input mode, input has_value, input value,
                    input end_of_stream, output ready);
endinterface

interface ssm_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [ssm_pkg::VALUE_W-1:0]   merged_value;
    logic                                 from_second;
    logic                                 status;
    logic                                 merge_done;

    modport source (output valid, output merged_value, output from_second,
                    output status, output merge_done, input ready);
    modport sink   (input valid, input merged_value, input from_second,
                    input status, input merge_done, output ready);
endinterface

>>> rtl/ssm_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// ssm_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module ssm_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 32,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/ssm_datapath.sv
`timescale 1ns / 1ps
// ============================================================================
// ssm_datapath
// Two element FIFOs, end-of-stream flags, head compare and output register.
// ============================================================================
module ssm_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ssm_pkg::ssm_cmd_t                   cmd,
    output ssm_pkg::ssm_status_t                status,
    input  logic                                mode,
    input  logic                                has_value,
    input  logic signed [ssm_pkg::VALUE_W-1:0]  value,
    input  logic                                end_of_stream,
    output logic signed [ssm_pkg::VALUE_W-1:0]  merged_value,
    output logic                                from_second,
    output logic                                status_bit,
    output logic                                merge_done
);

    localparam int PW = ssm_pkg::PTR_W;
    localparam int FW = ssm_pkg::FILL_W;
    localparam int VW = ssm_pkg::VALUE_W;

    logic [PW-1:0] f_rptr_reg, f_rptr_next, f_wptr_reg, f_wptr_next;
    logic [PW-1:0] s_rptr_reg, s_rptr_next, s_wptr_reg, s_wptr_next;
    logic [FW-1:0] f_fill_reg, f_fill_next, s_fill_reg, s_fill_next;
    logic          f_end_reg, f_end_next, s_end_reg, s_end_next;

    logic signed [VW-1:0] out_value_reg, out_value_next;
    logic                 out_second_reg, out_second_next;
    logic                 out_status_reg, out_status_next;
    logic                 out_done_reg, out_done_next;

    logic [VW-1:0]        f_head, s_head;
    logic                 f_we, s_we;
    logic                 f_full, s_full, f_empty, s_empty;
    logic                 pick_second;
    logic                 pop_f, pop_s;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        if (p == PW'(ssm_pkg::FIFO_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PW'(1);
        end
        return r;
    endfunction

    ssm_ram #(.WIDTH(VW), .DEPTH(ssm_pkg::FIFO_DEPTH)) u_first_ram (
        .clk   (clk),
        .we    (f_we),
        .waddr (f_wptr_reg),
        .wdata (value),
        .raddr (f_rptr_reg),
        .rdata (f_head)
    );

    ssm_ram #(.WIDTH(VW), .DEPTH(ssm_pkg::FIFO_DEPTH)) u_second_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_wptr_reg),
        .wdata (value),
        .raddr (s_rptr_reg),
        .rdata (s_head)
    );

    assign f_full  = (f_fill_reg == FW'(ssm_pkg::FIFO_DEPTH));
    assign s_full  = (s_fill_reg == FW'(ssm_pkg::FIFO_DEPTH));
    assign f_empty = (f_fill_reg == '0);
    assign s_empty = (s_fill_reg == '0);

    assign f_we = cmd.take_item && has_value && !mode && !f_full;
    assign s_we = cmd.take_item && has_value &&  mode && !s_full;

    // Ties go to the second stream; an ended, empty stream lets the other drain.
    always_comb
    begin
        pick_second = 1'b0;
        if (!f_empty && !s_empty)
        begin
            pick_second = ($signed(f_head) >= $signed(s_head));
        end
        else if (f_empty && f_end_reg && !s_empty)
        begin
            pick_second = 1'b1;
        end
    end

    assign status.ovf        = has_value && (mode ? s_full : f_full);
    assign status.sel_valid  = (!f_empty && !s_empty)
                            || (f_empty && f_end_reg && !s_empty)
                            || (s_empty && s_end_reg && !f_empty);
    assign status.merge_over = f_end_reg && s_end_reg && f_empty && s_empty;
    assign status.out_done   = out_done_reg;

    assign pop_f = cmd.load_pop && !pick_second;
    assign pop_s = cmd.load_pop &&  pick_second;

    always_comb
    begin
        f_rptr_next     = f_rptr_reg;
        f_wptr_next     = f_wptr_reg;
        s_rptr_next     = s_rptr_reg;
        s_wptr_next     = s_wptr_reg;
        f_fill_next     = f_fill_reg;
        s_fill_next     = s_fill_reg;
        f_end_next      = f_end_reg;
        s_end_next      = s_end_reg;
        out_value_next  = out_value_reg;
        out_second_next = out_second_reg;
        out_status_next = out_status_reg;
        out_done_next   = out_done_reg;

        if (f_we)
        begin
            f_wptr_next = wrap_inc(f_wptr_reg);
            f_fill_next = f_fill_reg + FW'(1);
        end
        if (s_we)
        begin
            s_wptr_next = wrap_inc(s_wptr_reg);
            s_fill_next = s_fill_reg + FW'(1);
        end
        if (cmd.take_item && end_of_stream)
        begin
            if (mode)
            begin
                s_end_next = 1'b1;
            end
            else
            begin
                f_end_next = 1'b1;
            end
        end

        if (cmd.load_ovf)
        begin
            out_value_next  = value;
            out_second_next = mode;
            out_status_next = 1'b1;
            out_done_next   = 1'b0;
        end

        if (pop_f)
        begin
            f_rptr_next     = wrap_inc(f_rptr_reg);
            f_fill_next     = f_fill_reg - FW'(1);
            out_value_next  = f_head;
            out_second_next = 1'b0;
            out_status_next = 1'b0;
            out_done_next   = f_end_reg && s_end_reg && s_empty
                           && (f_fill_reg == FW'(1));
        end
        if (pop_s)
        begin
            s_rptr_next     = wrap_inc(s_rptr_reg);
            s_fill_next     = s_fill_reg - FW'(1);
            out_value_next  = s_head;
            out_second_next = 1'b1;
            out_status_next = 1'b0;
            out_done_next   = f_end_reg && s_end_reg && f_empty
                           && (s_fill_reg == FW'(1));
        end

        if (cmd.load_marker)
        begin
            out_value_next  = '0;
            out_second_next = 1'b0;
            out_status_next = 1'b0;
            out_done_next   = 1'b1;
        end

        if (cmd.clear_merge)
        begin
            f_end_next  = 1'b0;
            s_end_next  = 1'b0;
            f_rptr_next = '0;
            f_wptr_next = '0;
            s_rptr_next = '0;
            s_wptr_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_rptr_reg <= '0;
            f_wptr_reg <= '0;
            s_rptr_reg <= '0;
            s_wptr_reg <= '0;
            f_fill_reg <= '0;
            s_fill_reg <= '0;
            f_end_reg  <= 1'b0;
            s_end_reg  <= 1'b0;
        end
        else
        begin
            f_rptr_reg <= f_rptr_next;
            f_wptr_reg <= f_wptr_next;
            s_rptr_reg <= s_rptr_next;
            s_wptr_reg <= s_wptr_next;
            f_fill_reg <= f_fill_next;
            s_fill_reg <= s_fill_next;
            f_end_reg  <= f_end_next;
            s_end_reg  <= s_end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg  <= out_value_next;
        out_second_reg <= out_second_next;
        out_status_reg <= out_status_next;
        out_done_reg   <= out_done_next;
    end

    assign merged_value = out_value_reg;
    assign from_second  = out_second_reg;
    assign status_bit   = out_status_reg;
    assign merge_done   = out_done_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (f_fill_reg <= FW'(ssm_pkg::FIFO_DEPTH)) && (s_fill_reg <= FW'(ssm_pkg::FIFO_DEPTH)))
        else $error("FIFO fill count beyond depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_pop |-> (pick_second ? !s_empty : !f_empty))
        else $error("pop from an empty FIFO");

    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_merge |-> (f_empty && s_empty && f_end_reg && s_end_reg))
        else $error("merge closed with data left or a stream still open");

endmodule

>>> rtl/ssm_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// ssm_ctrl
// Sequencer: takes one item, then emits its results one at a time.
// ============================================================================
module ssm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  ssm_pkg::ssm_status_t status,
    output ssm_pkg::ssm_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_FETCH  = 4'b0010,
        S_DECIDE = 4'b0100,
        S_EMIT   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_EMIT);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take_item = 1'b1;
                    if (status.ovf)
                    begin
                        cmd.load_ovf = 1'b1;
                        state_next   = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_FETCH;
                    end
                end
            end
            // RAM read latency after a write
            S_FETCH:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (status.sel_valid)
                begin
                    cmd.load_pop = 1'b1;
                    state_next   = S_EMIT;
                end
                else if (status.merge_over)
                begin
                    cmd.load_marker = 1'b1;
                    state_next      = S_EMIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (out_ready)
                begin
                    if (status.out_done)
                    begin
                        cmd.clear_merge = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_DECIDE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("input taken while a result is pending");

    a_done_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && status.out_done) |=> in_ready)
        else $error("merge end not followed by idle");

endmodule

>>> rtl/sorted_stream_merge.sv
`timescale 1ns / 1ps
// ============================================================================
// sorted_stream_merge
// Two-way merge of ascending signed streams through one FIFO per stream.
// ============================================================================
//  Channel   Dir  Fields
//  in_ch     in   mode, has_value, value[31:0], end_of_stream
//  out_ch    out  merged_value[31:0], from_second, status, merge_done
//
// One item at a time: accept, RAM fetch, then per result a head compare and
// an output register, plus a final compare to see that nothing is left.
// Without output stalls, an item that ends the merge skips that final compare;
// an item that overflows skips the fetch and reports straight from the accept.
// Rate is set by one item in flight and the registered RAM read feeding the compare.
// Reset clears pointers, fill counts and end flags at once; no clearing pass.
// A stall on out_ch holds the result and keeps in_ch.ready low.
// ============================================================================
module sorted_stream_merge (
    input  logic      clk,
    input  logic      rst_n,
    ssm_in_if.sink    in_ch,
    ssm_out_if.source out_ch
);

    ssm_pkg::ssm_cmd_t    cmd;
    ssm_pkg::ssm_status_t st;

    ssm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (st),
        .cmd       (cmd)
    );

    ssm_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (st),
        .mode          (in_ch.mode),
        .has_value     (in_ch.has_value),
        .value         (in_ch.value),
        .end_of_stream (in_ch.end_of_stream),
        .merged_value  (out_ch.merged_value),
        .from_second   (out_ch.from_second),
        .status_bit    (out_ch.status),
        .merge_done    (out_ch.merge_done)
    );

endmodule
